// File: hdl/rhht_pkg.sv
// Package for the Robin Hood hash table: default sizes, operation and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package rhht_pkg;

	localparam int DEF_CAPACITY    = 1024;
	localparam int DEF_KEY_WIDTH   = 32;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam int FILL_W   = 11;
	localparam int STATUS_W = 3;
	localparam int VOUT_W   = 32;
	localparam int OP_W     = 2;

	localparam logic [FILL_W-1:0] MAX_FILL_RESET = 11'd768;

	localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
	localparam logic [OP_W-1:0] OP_GET    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
	localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_CARRY,
		WR_VAL,
		WR_SWAP,
		WR_SHIFT,
		WR_FREE,
		WR_SWEEP
	} wr_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_ZERO
	} cnt_op_t;

	typedef struct packed {
		logic                load;
		wr_sel_t             wr;
		logic                adv;
		logic                shift_start;
		logic                sweep_inc;
		logic                take_vout;
		cnt_op_t             cnt_op;
		logic                out_load;
		logic [STATUS_W-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic used;
		logic key_match;
		logic matching;
		logic dist_gt;
		logic dist_zero;
		logic step_last;
		logic step_end;
		logic sweep_last;
		logic full;
	} sts_t;

endpackage

// File: hdl/rhht_dp.sv
// Datapath of the Robin Hood hash table: slot memory, probe registers, counters,
// fill limit register and result registers. Depends on rhht_pkg.
module rhht_dp #(
	parameter int CAPACITY    = rhht_pkg::DEF_CAPACITY,
	parameter int KEY_WIDTH   = rhht_pkg::DEF_KEY_WIDTH,
	parameter int VALUE_WIDTH = rhht_pkg::DEF_VALUE_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [KEY_WIDTH-1:0]               key,
	input  logic [VALUE_WIDTH-1:0]             value,
	input  logic                               cfg_we,
	input  logic [rhht_pkg::FILL_W-1:0]        cfg_data,
	input  rhht_pkg::cmd_t                     cmd,
	output rhht_pkg::sts_t                     sts,
	output logic [rhht_pkg::STATUS_W-1:0]      status,
	output logic [rhht_pkg::VOUT_W-1:0]        value_out,
	output logic [rhht_pkg::FILL_W-1:0]        entry_total
);
	import rhht_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = IDX_W + 1;
	localparam int CMP_W = (CNT_W > FILL_W) ? CNT_W + 1 : FILL_W + 1;

	logic                   used_mem [CAPACITY];
	logic [KEY_WIDTH-1:0]   key_mem  [CAPACITY];
	logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];
	logic [IDX_W-1:0]       dist_mem [CAPACITY];

	logic                   rd_used_s1;
	logic [KEY_WIDTH-1:0]   rd_key_s1;
	logic [VALUE_WIDTH-1:0] rd_val_s1;
	logic [IDX_W-1:0]       rd_dist_s1;

	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [KEY_WIDTH-1:0]   ck_q;
	logic [VALUE_WIDTH-1:0] cv_q;
	logic [CNT_W-1:0]       cd_q;
	logic                   matching_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       prev_q;
	logic [CNT_W-1:0]       step_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       sweep_q;
	logic [FILL_W-1:0]      max_fill_q;
	logic [VALUE_WIDTH-1:0] vout_q;

	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic                   wr_used;
	logic [KEY_WIDTH-1:0]   wr_key;
	logic [VALUE_WIDTH-1:0] wr_val;
	logic [IDX_W-1:0]       wr_dist;

	logic [KEY_WIDTH-1:0]   hash;
	logic [63:0]            hash_ext;
	logic [CMP_W-1:0]       cnt_ext;
	logic [CMP_W-1:0]       fill_ext;

	assign hash     = key ^ (key >> 16);
	assign hash_ext = 64'(hash);
	assign cnt_ext  = CMP_W'(cnt_q);
	assign fill_ext = CMP_W'(max_fill_q);

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = idx_q;
		wr_used = 1'b1;
		wr_key  = ck_q;
		wr_val  = cv_q;
		wr_dist = cd_q[IDX_W-1:0];
		case (cmd.wr)
			WR_NONE: begin
				wr_en = 1'b0;
			end
			WR_CARRY, WR_SWAP: begin
			end
			WR_VAL: begin
				wr_key  = rd_key_s1;
				wr_val  = val_q;
				wr_dist = rd_dist_s1;
			end
			WR_SHIFT: begin
				wr_addr = prev_q;
				wr_key  = rd_key_s1;
				wr_val  = rd_val_s1;
				wr_dist = rd_dist_s1 - 1'b1;
			end
			WR_FREE: begin
				wr_addr = prev_q;
				wr_used = 1'b0;
			end
			WR_SWEEP: begin
				wr_addr = sweep_q;
				wr_used = 1'b0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			used_mem[wr_addr] <= wr_used;
			key_mem[wr_addr]  <= wr_key;
			val_mem[wr_addr]  <= wr_val;
			dist_mem[wr_addr] <= wr_dist;
		end
		rd_used_s1 <= used_mem[idx_q];
		rd_key_s1  <= key_mem[idx_q];
		rd_val_s1  <= val_mem[idx_q];
		rd_dist_s1 <= dist_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q      <= key;
			val_q      <= value;
			ck_q       <= key;
			cv_q       <= value;
			cd_q       <= '0;
			matching_q <= 1'b1;
			idx_q      <= hash_ext[IDX_W-1:0];
			step_q     <= '0;
			vout_q     <= '0;
		end else begin
			if (cmd.wr == WR_SWAP) begin
				ck_q       <= rd_key_s1;
				cv_q       <= rd_val_s1;
				matching_q <= 1'b0;
			end
			if (cmd.adv) begin
				prev_q <= idx_q;
				idx_q  <= idx_q + 1'b1;
				step_q <= step_q + 1'b1;
				if (cmd.wr == WR_SWAP) begin
					cd_q <= CNT_W'(rd_dist_s1) + 1'b1;
				end else begin
					cd_q <= cd_q + 1'b1;
				end
			end
			if (cmd.shift_start) begin
				prev_q <= idx_q;
				idx_q  <= idx_q + 1'b1;
				step_q <= CNT_W'(1);
			end
			if (cmd.take_vout) begin
				vout_q <= rd_val_s1;
			end
		end
		if (cmd.out_load) begin
			status      <= cmd.code;
			value_out   <= VOUT_W'(vout_q);
			entry_total <= FILL_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			sweep_q    <= '0;
			max_fill_q <= MAX_FILL_RESET;
		end else begin
			if (cfg_we) begin
				max_fill_q <= cfg_data;
			end
			if (cmd.sweep_inc) begin
				sweep_q <= sweep_q + 1'b1;
			end
			case (cmd.cnt_op)
				CNT_INC:  cnt_q <= cnt_q + 1'b1;
				CNT_DEC:  cnt_q <= cnt_q - 1'b1;
				CNT_ZERO: cnt_q <= '0;
				default:  cnt_q <= cnt_q;
			endcase
		end
	end

	assign sts.used       = rd_used_s1;
	assign sts.key_match  = (rd_key_s1 == key_q);
	assign sts.matching   = matching_q;
	assign sts.dist_gt    = (cd_q > CNT_W'(rd_dist_s1));
	assign sts.dist_zero  = (rd_dist_s1 == '0);
	assign sts.step_last  = (step_q == CNT_W'(CAPACITY - 1));
	assign sts.step_end   = (step_q == CNT_W'(CAPACITY));
	assign sts.sweep_last = (sweep_q == IDX_W'(CAPACITY - 1));
	assign sts.full       = ((cnt_ext + 1'b1) > fill_ext) || (cnt_ext >= CMP_W'(CAPACITY));

endmodule

// File: hdl/rhht_ctrl.sv
// Controller of the Robin Hood hash table: sequences probe, swap, shift and
// clearing passes and the result handshake. Depends on rhht_pkg.
module rhht_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [rhht_pkg::OP_W-1:0] op,
	output logic                      out_valid,
	input  logic                      out_stall,
	input  rhht_pkg::sts_t            sts,
	output rhht_pkg::cmd_t            cmd
);
	import rhht_pkg::*;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_RD,
		S_EV,
		S_SH_RD,
		S_SH_EV,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [STATUS_W-1:0] code_q;
	logic                boot_q;
	logic                out_valid_q;
	logic                out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd             = '0;
		cmd.wr          = WR_NONE;
		cmd.cnt_op      = CNT_HOLD;
		cmd.code        = code_q;
		unique case (state_q)
			S_SWEEP: begin
				cmd.wr        = WR_SWEEP;
				cmd.sweep_inc = 1'b1;
				if (sts.sweep_last) begin
					cmd.cnt_op = CNT_ZERO;
				end
			end
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_RD, S_SH_RD: begin
			end
			S_EV: begin
				if (op_q == OP_PUT) begin
					if (!sts.used) begin
						cmd.wr     = WR_CARRY;
						cmd.cnt_op = CNT_INC;
					end else if (sts.matching && sts.key_match) begin
						cmd.wr = WR_VAL;
					end else begin
						cmd.adv = 1'b1;
						if (sts.dist_gt) begin
							cmd.wr = WR_SWAP;
						end
					end
				end else if (sts.used && !sts.dist_gt) begin
					if (sts.key_match) begin
						if (op_q == OP_GET) begin
							cmd.take_vout = 1'b1;
						end else begin
							cmd.shift_start = 1'b1;
						end
					end else begin
						cmd.adv = 1'b1;
					end
				end
			end
			S_SH_EV: begin
				if (sts.step_end || !sts.used || sts.dist_zero) begin
					cmd.wr     = WR_FREE;
					cmd.cnt_op = CNT_DEC;
				end else begin
					cmd.wr  = WR_SHIFT;
					cmd.adv = 1'b1;
				end
			end
			S_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			op_q        <= OP_PUT;
			code_q      <= ST_CLEARED;
			boot_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					if (sts.sweep_last) begin
						boot_q  <= 1'b0;
						state_q <= boot_q ? S_IDLE : S_DONE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q <= op;
						unique case (op)
							OP_CLEAR: begin
								code_q  <= ST_CLEARED;
								state_q <= S_SWEEP;
							end
							OP_PUT: begin
								if (sts.full) begin
									code_q  <= ST_FULL;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD;
								end
							end
							default: begin
								state_q <= S_RD;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (op_q == OP_PUT) begin
						if (!sts.used) begin
							code_q  <= ST_INSERTED;
							state_q <= S_DONE;
						end else if (sts.matching && sts.key_match) begin
							code_q  <= ST_UPDATED;
							state_q <= S_DONE;
						end else if (sts.step_last) begin
							code_q  <= ST_FULL;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end else if (!sts.used || sts.dist_gt) begin
						code_q  <= ST_NOT_FOUND;
						state_q <= S_DONE;
					end else if (sts.key_match) begin
						if (op_q == OP_GET) begin
							code_q  <= ST_FOUND;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SH_RD;
						end
					end else if (sts.step_last) begin
						code_q  <= ST_NOT_FOUND;
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_EV;
				end
				S_SH_EV: begin
					if (sts.step_end || !sts.used || sts.dist_zero) begin
						code_q  <= ST_REMOVED;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SH_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/robin_hood_hash_table.sv
// Top level of the Robin Hood hash table: joins controller and datapath.
// Depends on rhht_pkg, rhht_ctrl and rhht_dp.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  op, key, value
//   out      out_valid/out_stall  status, value_out, entry_total
//   cfg      cfg_valid/cfg_ready  max_fill
//
// Each probed or shifted slot is read on the single memory read port (S_RD or S_SH_RD)
// and then evaluated (S_EV or S_SH_EV); put, get and remove also pass through S_IDLE to
// accept the request and S_DONE to post the result. Clear sweeps every slot.
// After reset the same sweep runs before the first transaction.
// One transaction is in work at a time; a stalled result holds the next result back.
module robin_hood_hash_table #(
	parameter int CAPACITY    = rhht_pkg::DEF_CAPACITY,
	parameter int KEY_WIDTH   = rhht_pkg::DEF_KEY_WIDTH,
	parameter int VALUE_WIDTH = rhht_pkg::DEF_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rhht_pkg::OP_W-1:0]     op,
	input  logic [KEY_WIDTH-1:0]          key,
	input  logic [VALUE_WIDTH-1:0]        value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rhht_pkg::STATUS_W-1:0] status,
	output logic [rhht_pkg::VOUT_W-1:0]   value_out,
	output logic [rhht_pkg::FILL_W-1:0]   entry_total,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rhht_pkg::FILL_W-1:0]   max_fill
);
	import rhht_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	rhht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rhht_dp #(
		.CAPACITY    (CAPACITY),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.key         (key),
		.value       (value),
		.cfg_we      (cfg_valid),
		.cfg_data    (max_fill),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.value_out   (value_out),
		.entry_total (entry_total)
	);

endmodule

// File: dv/tb_robin_hood_hash_table.sv
// Self-checking testbench for the Robin Hood hash table: a tracking model of the
// slot array predicts every result, which the monitor compares field by field.
// Depends on rhht_pkg and robin_hood_hash_table.
module tb_robin_hood_hash_table;
	import rhht_pkg::*;

	localparam int CAP = DEF_CAPACITY;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [31:0]     key;
		logic [31:0]     value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [31:0]         value_out;
		logic [FILL_W-1:0]   entry_total;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] op = OP_GET;
	logic [31:0] key = '0;
	logic [31:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [31:0] value_out;
	logic [FILL_W-1:0] entry_total;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [FILL_W-1:0] max_fill = '0;

	robin_hood_hash_table DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .key(key), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.value_out(value_out), .entry_total(entry_total),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .max_fill(max_fill)
	);

	// Table model.
	bit          tbl_used [CAP];
	logic [31:0] tbl_key [CAP];
	logic [31:0] tbl_val [CAP];
	int unsigned tbl_dist [CAP];
	int unsigned tbl_count;
	int unsigned fill_limit = MAX_FILL_RESET;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	logic [31:0] known_keys[$];
	int mismatches = 0;
	int unsigned cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	bit pending_empty;

	function automatic int unsigned home_of(logic [31:0] k);
		return (k ^ (k >> 16)) & (CAP - 1);
	endfunction

	function automatic int lookup_slot(logic [31:0] k);
		int unsigned idx;
		idx = home_of(k);
		for (int unsigned d = 0; d < CAP; d++) begin
			if (!tbl_used[idx] || d > tbl_dist[idx])
				return -1;
			if (tbl_key[idx] == k)
				return idx;
			idx = (idx + 1) & (CAP - 1);
		end
		return -1;
	endfunction

	function automatic logic [STATUS_W-1:0] model_put(logic [31:0] k, logic [31:0] v);
		logic [31:0] ck, cv, tk, tv;
		int unsigned cd, td, idx;
		bit matching;
		ck = k;
		cv = v;
		cd = 0;
		matching = 1'b1;
		if (tbl_count + 1 > fill_limit || tbl_count >= CAP)
			return ST_FULL;
		idx = home_of(k);
		for (int unsigned s = 0; s < CAP; s++) begin
			if (!tbl_used[idx]) begin
				tbl_used[idx] = 1'b1;
				tbl_key[idx] = ck;
				tbl_val[idx] = cv;
				tbl_dist[idx] = cd;
				tbl_count++;
				return ST_INSERTED;
			end
			if (matching && tbl_key[idx] == k) begin
				tbl_val[idx] = v;
				return ST_UPDATED;
			end
			if (cd > tbl_dist[idx]) begin
				tk = tbl_key[idx];
				tv = tbl_val[idx];
				td = tbl_dist[idx];
				tbl_key[idx] = ck;
				tbl_val[idx] = cv;
				tbl_dist[idx] = cd;
				ck = tk;
				cv = tv;
				cd = td;
				matching = 1'b0;
			end
			cd++;
			idx = (idx + 1) & (CAP - 1);
		end
		return ST_FULL;
	endfunction

	function automatic logic [STATUS_W-1:0] model_remove(logic [31:0] k);
		int found;
		int unsigned idx, prev;
		found = lookup_slot(k);
		if (found < 0)
			return ST_NOT_FOUND;
		tbl_used[found] = 1'b0;
		prev = found;
		idx = (prev + 1) & (CAP - 1);
		for (int unsigned s = 1; s < CAP; s++) begin
			if (!tbl_used[idx] || tbl_dist[idx] == 0)
				break;
			tbl_used[prev] = 1'b1;
			tbl_key[prev] = tbl_key[idx];
			tbl_val[prev] = tbl_val[idx];
			tbl_dist[prev] = tbl_dist[idx] - 1;
			tbl_used[idx] = 1'b0;
			prev = idx;
			idx = (idx + 1) & (CAP - 1);
		end
		if (tbl_count > 0)
			tbl_count--;
		return ST_REMOVED;
	endfunction

	function automatic rsp_t predict_table_op(req_t r);
		rsp_t p;
		int found;
		p.value_out = '0;
		case (r.op)
			OP_PUT: begin
				p.status = model_put(r.key, r.value);
			end
			OP_GET: begin
				found = lookup_slot(r.key);
				if (found >= 0) begin
					p.status = ST_FOUND;
					p.value_out = tbl_val[found];
				end else begin
					p.status = ST_NOT_FOUND;
				end
			end
			OP_REMOVE: begin
				p.status = model_remove(r.key);
			end
			default: begin
				for (int i = 0; i < CAP; i++)
					tbl_used[i] = 1'b0;
				tbl_count = 0;
				p.status = ST_CLEARED;
			end
		endcase
		p.entry_total = tbl_count[FILL_W-1:0];
		return p;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 40000000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Driver: a valid item stays put until accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (in_valid)
					expected_rsps.push_back(predict_table_op('{op, key, value}));
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req_t r;
					r = pending_reqs.pop_front();
					in_valid <= 1'b1;
					op <= r.op;
					key <= r.key;
					value <= r.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d value %h total %0d",
							status, value_out, entry_total);
				end else begin
					rsp_t e;
					e = expected_rsps.pop_front();
					if (e.status !== status || e.value_out !== value_out ||
							e.entry_total !== entry_total) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d/%h/%0d got %0d/%h/%0d",
								e.status, e.value_out, e.entry_total,
								status, value_out, entry_total);
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic logic [31:0] pick_key();
		int unsigned c;
		c = $urandom_range(9);
		if (known_keys.size() > 0 && c < 6)
			return known_keys[$urandom_range(known_keys.size() - 1)];
		if (c < 8)
			return {16'($urandom_range(15)), 6'd0, 10'($urandom_range(31))};
		return $urandom;
	endfunction

	task automatic queue_req(logic [OP_W-1:0] o, logic [31:0] k, logic [31:0] v);
		pending_reqs.push_back('{o, k, v});
		if (o == OP_PUT && known_keys.size() < 200)
			known_keys.push_back(k);
	endtask

	task automatic queue_random(int n);
		int unsigned c;
		for (int i = 0; i < n; i++) begin
			c = $urandom_range(99);
			if (c < 45)
				queue_req(OP_PUT, pick_key(), $urandom);
			else if (c < 75)
				queue_req(OP_GET, pick_key(), $urandom);
			else if (c < 98)
				queue_req(OP_REMOVE, pick_key(), $urandom);
			else
				queue_req(OP_CLEAR, pick_key(), $urandom);
		end
	endtask

	task automatic drain();
		do begin
			@(posedge clk);
			pending_empty = (pending_reqs.size() == 0 && !in_valid && hold_cycles == 0
				&& expected_rsps.size() == 0);
		end while (!pending_empty);
		repeat (2 * CAP + 20) @(posedge clk);
	endtask

	task automatic write_fill_limit(logic [FILL_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		max_fill <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		fill_limit = v;
	endtask

	initial begin
		for (int i = 0; i < CAP; i++) begin
			tbl_used[i] = 1'b0;
			tbl_dist[i] = 0;
		end
		tbl_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, colliding homes, wrap, every operation and every status but full.
		queue_req(OP_GET, 32'h0, 32'h0);
		queue_req(OP_PUT, 32'h0, 32'hFFFFFFFF);
		queue_req(OP_PUT, 32'hFFFFFFFF, 32'h0);
		queue_req(OP_PUT, 32'h00010001, 32'h12345678);
		queue_req(OP_PUT, 32'h00000400, 32'hA5A5A5A5);
		queue_req(OP_PUT, 32'h000003FF, 32'h5A5A5A5A);
		queue_req(OP_PUT, 32'h000007FF, 32'h1);
		queue_req(OP_PUT, 32'h0, 32'h87654321);
		queue_req(OP_GET, 32'h0, 32'h0);
		queue_req(OP_GET, 32'h00000400, 32'h0);
		queue_req(OP_GET, 32'hDEADBEEF, 32'h0);
		queue_req(OP_REMOVE, 32'h0, 32'h0);
		queue_req(OP_GET, 32'h00000400, 32'h0);
		queue_req(OP_REMOVE, 32'h0, 32'h0);
		queue_req(OP_REMOVE, 32'h000003FF, 32'h0);
		queue_req(OP_GET, 32'h000007FF, 32'h0);
		queue_req(OP_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF);
		queue_req(OP_GET, 32'hFFFFFFFF, 32'h0);
		drain();

		// A fill limit of zero refuses every put.
		write_fill_limit('0);
		queue_req(OP_PUT, 32'h5, 32'h5);
		queue_req(OP_GET, 32'h5, 32'h0);
		drain();

		// A limit of one: updates of the sole key are refused too.
		write_fill_limit(11'd1);
		queue_req(OP_PUT, 32'h7, 32'h1);
		queue_req(OP_PUT, 32'h7, 32'h2);
		queue_req(OP_PUT, 32'h8, 32'h3);
		queue_req(OP_CLEAR, 32'h0, 32'h0);
		queue_random(20);
		drain();

		// Largest limit; the table fills completely, then full-table lookups.
		write_fill_limit(11'h7FF);
		for (int i = 0; i < CAP + 4; i++)
			queue_req(OP_PUT, $urandom, $urandom);
		queue_req(OP_GET, 32'hCAFEF00D, 32'h0);
		queue_req(OP_REMOVE, 32'hCAFEF00D, 32'h0);
		queue_random(20);
		queue_req(OP_CLEAR, 32'h0, 32'h0);
		drain();

		// Random phases at varied limits, idling and receiver stalls.
		write_fill_limit(11'd24);
		queue_random(40);
		drain();

		write_fill_limit(11'd1024);
		send_idle_pct = 67;
		queue_random(40);
		drain();

		write_fill_limit(MAX_FILL_RESET);
		send_idle_pct = 0;
		stall_pct = 67;
		queue_random(40);
		hold_cycles = 3000;
		drain();

		write_fill_limit(11'd40);
		send_idle_pct = 29;
		stall_pct = 29;
		queue_random(40);
		drain();

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// File: files.f
hdl/rhht_pkg.sv
hdl/rhht_dp.sv
hdl/rhht_ctrl.sv
hdl/robin_hood_hash_table.sv
dv/tb_robin_hood_hash_table.sv
